// ===== src/iirfb_pkg.sv =====
// Shared types and constants for the IIR filter bank with summed output.
// No dependencies; every other file of the block imports this package.
package iirfb_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COEFF_W    = 32;
    localparam int OP_W       = 2;
    localparam int FIDX_W     = 3;
    localparam int TIDX_W     = 4;
    localparam int FCFG_W     = 4;
    localparam int TCFG_W     = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // request operations; the fourth code is ignored
    localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTERS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TERMS_IN_USE   = 1'b1;

    localparam logic [TCFG_W-1:0] TERMS_RESET = 5'd16;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic [FIDX_W-1:0]          filter_index;
        logic [TIDX_W-1:0]          term_index;
        logic signed [COEFF_W-1:0]  numerator_coeff;
        logic signed [COEFF_W-1:0]  denominator_coeff;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_sum;
        logic                       saturated;
    } res_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic x_we;
        logic sample_we;
        logic coef_we;
        logic load_we;
        logic hist_clear;
        logic start;
        logic issue;
        logic first;
        logic last;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== src/iirfb_req_if.sv =====
// Request channel of the filter bank: valid/ready handshake with a req_t payload.
// Depends on iirfb_pkg.
interface iirfb_req_if
    import iirfb_pkg::*;
;
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/iirfb_res_if.sv =====
// Result channel of the filter bank: valid/ready handshake with a res_t payload.
// Depends on iirfb_pkg.
interface iirfb_res_if
    import iirfb_pkg::*;
;
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/iirfb_ctrl.sv =====
// Sequencer of the filter bank: configuration registers, history position,
// memory sweeps and the term/filter issue loop. Depends on iirfb_pkg.
module iirfb_ctrl
    import iirfb_pkg::*;
#(
    parameter int MAX_FILTERS = 8,
    parameter int MAX_TERMS   = 16,
    localparam int DEPTH      = MAX_FILTERS * MAX_TERMS,
    localparam int ADDR_W     = $clog2(DEPTH),
    localparam int POS_W      = $clog2(MAX_TERMS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [FIDX_W-1:0]     filter_index,
    input  logic [TIDX_W-1:0]     term_index,
    input  ctrl_status_t          status,
    output ctrl_cmd_t             cmd,
    output logic [ADDR_W-1:0]     sweep_addr,
    output logic [POS_W-1:0]      x_waddr,
    output logic [POS_W-1:0]      x_raddr,
    output logic [ADDR_W-1:0]     coef_waddr,
    output logic [ADDR_W-1:0]     coef_raddr,
    output logic [ADDR_W-1:0]     hist_raddr,
    output logic [ADDR_W-1:0]     wb_addr
);

    localparam int TCNT_W = $clog2(MAX_TERMS + 1);
    localparam int FCNT_W = $clog2(MAX_FILTERS + 1);

    state_t              state_reg, state_next;
    logic [FCFG_W-1:0]   filters_reg;
    logic [TCFG_W-1:0]   terms_reg;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    slot_reg, slot_next;
    logic [POS_W-1:0]    term_reg, term_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [FCNT_W-1:0]   filt_reg, filt_next;
    logic [ADDR_W-1:0]   sweep_reg, sweep_next;

    logic [TCNT_W-1:0]   nt;
    logic [FCNT_W-1:0]   nf;
    logic [POS_W-1:0]    pos_step;
    logic [POS_W-1:0]    slot_wrap;
    logic                accept;
    logic                sweeping;
    logic                sweep_last;
    logic                term_last;
    logic                filt_last;
    logic                load_ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filters_reg <= '0;
            terms_reg   <= TERMS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTERS_IN_USE: filters_reg <= cfg_data[FCFG_W-1:0];
                REG_TERMS_IN_USE:   terms_reg   <= cfg_data[TCFG_W-1:0];
            endcase
        end
    end

    // clamp the counts to what the storage holds
    always_comb
    begin
        if (terms_reg == '0)
            nt = TCNT_W'(1);
        else if (int'(terms_reg) > MAX_TERMS)
            nt = TCNT_W'(MAX_TERMS);
        else
            nt = TCNT_W'(terms_reg);

        if (int'(filters_reg) > MAX_FILTERS)
            nf = FCNT_W'(MAX_FILTERS);
        else
            nf = FCNT_W'(filters_reg);
    end

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign sweeping   = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign sweep_last = (sweep_reg == ADDR_W'(DEPTH - 1));
    assign term_last  = ((TCNT_W'(term_reg) + 1'b1) == nt);
    assign filt_last  = ((filt_reg + 1'b1) == nf);
    assign load_ok    = (int'(filter_index) < MAX_FILTERS) && (int'(term_index) < MAX_TERMS);

    // position moves down by one and wraps to the top of the active window
    assign pos_step  = ((pos_reg == '0) || (TCNT_W'(pos_reg) >= nt))
                       ? POS_W'(nt - 1'b1) : pos_reg - 1'b1;
    assign slot_wrap = ((TCNT_W'(slot_reg) + 1'b1) == nt) ? '0 : slot_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_FILTER: state_next = (nf == '0) ? ST_DONE : ST_RUN;
                        OP_CLEAR:  state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (sweep_last)
                    state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                if (term_last && filt_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // counters
    always_comb
    begin
        pos_next   = pos_reg;
        slot_next  = slot_reg;
        term_next  = term_reg;
        base_next  = base_reg;
        filt_next  = filt_reg;
        sweep_next = sweep_reg;

        if (sweeping)
            sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;

        if (accept && (operation == OP_CLEAR))
            pos_next = '0;

        if (accept && (operation == OP_FILTER))
        begin
            pos_next  = pos_step;
            slot_next = pos_step;
            term_next = '0;
            base_next = '0;
            filt_next = '0;
        end

        if (state_reg == ST_RUN)
        begin
            if (term_last)
            begin
                term_next = '0;
                slot_next = pos_reg;
                base_next = base_reg + ADDR_W'(MAX_TERMS);
                filt_next = filt_reg + 1'b1;
            end
            else
            begin
                term_next = term_reg + 1'b1;
                slot_next = slot_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            pos_reg   <= '0;
            slot_reg  <= '0;
            term_reg  <= '0;
            base_reg  <= '0;
            filt_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            slot_reg  <= slot_next;
            term_reg  <= term_next;
            base_reg  <= base_next;
            filt_reg  <= filt_next;
            sweep_reg <= sweep_next;
        end
    end

    // outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);

        cmd            = '0;
        cmd.x_we       = (sweeping && (int'(sweep_reg) < MAX_TERMS))
                         || (accept && (operation == OP_FILTER));
        cmd.sample_we  = accept && (operation == OP_FILTER);
        cmd.coef_we    = (state_reg == ST_INIT)
                         || (accept && (operation == OP_LOAD) && load_ok);
        cmd.load_we    = accept && (operation == OP_LOAD) && load_ok;
        cmd.hist_clear = sweeping;
        cmd.start      = accept && (operation == OP_FILTER);
        cmd.issue      = (state_reg == ST_RUN);
        cmd.first      = (term_reg == '0);
        cmd.last       = term_last;
        cmd.finish     = (state_reg == ST_DONE) && status.out_free;

        sweep_addr = sweep_reg;
        x_waddr    = sweeping ? sweep_reg[POS_W-1:0] : pos_step;
        x_raddr    = slot_reg;
        coef_waddr = (state_reg == ST_INIT) ? sweep_reg
                     : ADDR_W'(int'(filter_index) * MAX_TERMS + int'(term_index));
        coef_raddr = base_reg + ADDR_W'(term_reg);
        hist_raddr = base_reg + ADDR_W'(slot_reg);
        wb_addr    = base_reg + ADDR_W'(pos_reg);
    end

    a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (TCNT_W'(slot_reg) < nt))
        else $error("history slot left the active window");

    a_filter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (filt_reg < nf))
        else $error("filter counter passed the filter count");

    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !status.busy)
        else $error("sum taken while terms still in flight");

endmodule

// ===== src/iirfb_datapath.sv =====
// Datapath of the filter bank: history and coefficient memories, two
// multipliers, accumulator, saturation and result register. Depends on iirfb_pkg.
module iirfb_datapath
    import iirfb_pkg::*;
#(
    parameter int MAX_FILTERS     = 8,
    parameter int MAX_TERMS       = 16,
    parameter int COEFF_FRAC_BITS = 28,
    localparam int DEPTH          = MAX_FILTERS * MAX_TERMS,
    localparam int ADDR_W         = $clog2(DEPTH),
    localparam int POS_W          = $clog2(MAX_TERMS)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  cmd,
    output ctrl_status_t               status,
    input  logic [ADDR_W-1:0]          sweep_addr,
    input  logic [POS_W-1:0]           x_waddr,
    input  logic [POS_W-1:0]           x_raddr,
    input  logic [ADDR_W-1:0]          coef_waddr,
    input  logic [ADDR_W-1:0]          coef_raddr,
    input  logic [ADDR_W-1:0]          hist_raddr,
    input  logic [ADDR_W-1:0]          wb_addr,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic signed [COEFF_W-1:0]  numerator_coeff,
    input  logic signed [COEFF_W-1:0]  denominator_coeff,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] filtered_sum,
    output logic                       saturated
);

    localparam int PROD_W = SAMPLE_W + COEFF_W - COEFF_FRAC_BITS;
    localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_TERMS);
    localparam int TOT_W  = SAMPLE_W + 1 + $clog2(MAX_FILTERS);
    localparam int MUL_W  = SAMPLE_W + COEFF_W;

    logic signed [SAMPLE_W-1:0] x_mem   [MAX_TERMS];
    logic signed [SAMPLE_W-1:0] yh_mem  [DEPTH];
    logic signed [COEFF_W-1:0]  num_mem [DEPTH];
    logic signed [COEFF_W-1:0]  den_mem [DEPTH];

    logic signed [SAMPLE_W-1:0] x_rd_reg, y_rd_reg;
    logic signed [COEFF_W-1:0]  num_rd_reg, den_rd_reg;
    logic signed [MUL_W-1:0]    p_num_reg, p_den_reg;
    logic signed [PROD_W:0]     diff_reg, diff_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [TOT_W-1:0]    total_reg, total_next;
    logic                       clip_reg;

    logic                       v1_reg, v2_reg, v3_reg, yv_reg;
    logic                       first1_reg, first2_reg, first3_reg;
    logic                       last1_reg, last2_reg, last3_reg;
    logic [ADDR_W-1:0]          wb1_reg, wb2_reg, wb3_reg, wb4_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sum_reg;
    logic                       out_sat_reg;

    logic signed [PROD_W-1:0]   sb, sa, sa_g;
    logic                       acc_hi, acc_lo, tot_hi, tot_lo;
    logic signed [SAMPLE_W-1:0] y_sat, sum_sat;
    logic                       hist_we;
    logic [ADDR_W-1:0]          hist_waddr;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.x_we)
            x_mem[x_waddr] <= cmd.sample_we ? sample : '0;
        x_rd_reg <= x_mem[x_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coef_we)
        begin
            num_mem[coef_waddr] <= cmd.load_we ? numerator_coeff : '0;
            den_mem[coef_waddr] <= cmd.load_we ? denominator_coeff : '0;
        end
        num_rd_reg <= num_mem[coef_raddr];
        den_rd_reg <= den_mem[coef_raddr];
    end

    assign hist_we    = cmd.hist_clear || yv_reg;
    assign hist_waddr = cmd.hist_clear ? sweep_addr : wb4_reg;

    always_ff @(posedge clk)
    begin
        if (hist_we)
            yh_mem[hist_waddr] <= cmd.hist_clear ? '0 : y_sat;
        y_rd_reg <= yh_mem[hist_raddr];
    end

    // floor shift back to Q16.16 is a plain select of the upper bits
    assign sb = p_num_reg[MUL_W-1:COEFF_FRAC_BITS];
    assign sa = p_den_reg[MUL_W-1:COEFF_FRAC_BITS];

    always_comb
    begin
        // drop the delay-zero denominator term
        sa_g      = first2_reg ? '0 : sa;
        diff_next = (PROD_W + 1)'(sb) - (PROD_W + 1)'(sa_g);
        acc_next  = first3_reg ? ACC_W'(diff_reg) : acc_reg + ACC_W'(diff_reg);
    end

    always_comb
    begin
        acc_hi = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:SAMPLE_W-1]);
        acc_lo = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:SAMPLE_W-1]);
        if (acc_hi)
            y_sat = SAT_MAX;
        else if (acc_lo)
            y_sat = SAT_MIN;
        else
            y_sat = acc_reg[SAMPLE_W-1:0];

        tot_hi = !total_reg[TOT_W-1] && (|total_reg[TOT_W-2:SAMPLE_W-1]);
        tot_lo = total_reg[TOT_W-1] && !(&total_reg[TOT_W-2:SAMPLE_W-1]);
        if (tot_hi)
            sum_sat = SAT_MAX;
        else if (tot_lo)
            sum_sat = SAT_MIN;
        else
            sum_sat = total_reg[SAMPLE_W-1:0];

        total_next = total_reg + TOT_W'(y_sat);
    end

    // arithmetic pipeline
    always_ff @(posedge clk)
    begin
        p_num_reg <= x_rd_reg * num_rd_reg;
        p_den_reg <= y_rd_reg * den_rd_reg;
        diff_reg  <= diff_next;
        if (v3_reg)
            acc_reg <= acc_next;
        first1_reg <= cmd.first;
        first2_reg <= first1_reg;
        first3_reg <= first2_reg;
        last1_reg  <= cmd.last;
        last2_reg  <= last1_reg;
        last3_reg  <= last2_reg;
        wb1_reg    <= wb_addr;
        wb2_reg    <= wb1_reg;
        wb3_reg    <= wb2_reg;
        wb4_reg    <= wb3_reg;
        if (cmd.finish)
        begin
            out_sum_reg <= sum_sat;
            out_sat_reg <= clip_reg || tot_hi || tot_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            yv_reg        <= 1'b0;
            total_reg     <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            yv_reg <= v3_reg && last3_reg;

            if (cmd.start)
            begin
                total_reg <= '0;
                clip_reg  <= 1'b0;
            end
            else if (yv_reg)
            begin
                total_reg <= total_next;
                clip_reg  <= clip_reg || acc_hi || acc_lo;
            end

            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.busy     = v1_reg || v2_reg || v3_reg || yv_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign filtered_sum = out_sum_reg;
    assign saturated    = out_sat_reg;

    a_wb_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        yv_reg |-> $past(v3_reg && last3_reg))
        else $error("filter output written without a closing term");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result appeared without a finished sample");

    a_no_wb_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_clear |-> !yv_reg)
        else $error("history sweep collided with a filter output write");

endmodule

// ===== src/iir_filter_bank_sum.sv =====
// Top level of the IIR filter bank with summed output.
// Depends on iirfb_pkg, iirfb_req_if, iirfb_res_if, iirfb_ctrl, iirfb_datapath.
//
// A bank of up to MAX_FILTERS direct-form-I IIR filters that all see the same
// Q16.16 sample; their saturated outputs are added into one saturated result.
// A filter request (operation 0) issues filters_in_use * terms_in_use terms,
// one numerator and one denominator product per cycle through the two shared
// multipliers and the single read port of each memory, then drains the
// pipeline and hands the sum to the output register; with no active filter
// it goes straight to the handoff. A load request writes one coefficient pair
// and leaves the request channel ready. A clear request sweeps the history
// memories, one entry per cycle, over all MAX_FILTERS * MAX_TERMS addresses;
// after reset the same sweep also zeroes the coefficient tables, and the
// request channel stays not ready until that sweep ends.
// Configuration writes are taken at any time but are only meaningful while
// the block is idle. A finished result waits in an output register, so the
// next request is accepted while the result is still pending.
module iir_filter_bank_sum
    import iirfb_pkg::*;
#(
    parameter int MAX_FILTERS     = 8,
    parameter int MAX_TERMS       = 16,
    parameter int COEFF_FRAC_BITS = 28
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    iirfb_req_if.sink             request,
    iirfb_res_if.source           result
);

    localparam int DEPTH  = MAX_FILTERS * MAX_TERMS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_TERMS);

    ctrl_cmd_t         cmd;
    ctrl_status_t      status;
    logic [ADDR_W-1:0] sweep_addr;
    logic [POS_W-1:0]  x_waddr;
    logic [POS_W-1:0]  x_raddr;
    logic [ADDR_W-1:0] coef_waddr;
    logic [ADDR_W-1:0] coef_raddr;
    logic [ADDR_W-1:0] hist_raddr;
    logic [ADDR_W-1:0] wb_addr;

    // Sequencer: holds the configuration, steps the shared history position,
    // runs the reset and clear sweeps and walks filters and terms.
    iirfb_ctrl #(
        .MAX_FILTERS (MAX_FILTERS),
        .MAX_TERMS   (MAX_TERMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (request.valid),
        .in_ready     (request.ready),
        .operation    (request.payload.operation),
        .filter_index (request.payload.filter_index),
        .term_index   (request.payload.term_index),
        .status       (status),
        .cmd          (cmd),
        .sweep_addr   (sweep_addr),
        .x_waddr      (x_waddr),
        .x_raddr      (x_raddr),
        .coef_waddr   (coef_waddr),
        .coef_raddr   (coef_raddr),
        .hist_raddr   (hist_raddr),
        .wb_addr      (wb_addr)
    );

    // Datapath: memories, multiply-accumulate pipeline, saturation and the
    // output register that holds a result until the sink takes it.
    iirfb_datapath #(
        .MAX_FILTERS     (MAX_FILTERS),
        .MAX_TERMS       (MAX_TERMS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .sweep_addr        (sweep_addr),
        .x_waddr           (x_waddr),
        .x_raddr           (x_raddr),
        .coef_waddr        (coef_waddr),
        .coef_raddr        (coef_raddr),
        .hist_raddr        (hist_raddr),
        .wb_addr           (wb_addr),
        .sample            (request.payload.sample),
        .numerator_coeff   (request.payload.numerator_coeff),
        .denominator_coeff (request.payload.denominator_coeff),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .filtered_sum      (result.payload.filtered_sum),
        .saturated         (result.payload.saturated)
    );

endmodule
